// ----- rtl/owbm_pkg.sv -----
// Shared types and constants for the one-wire bus master unit.
// No dependencies; imported by every other file of the block.
package owbm_pkg;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int TIME_W = 16;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        REG_RESET_LOW   = 3'd0,
        REG_PRES_WAIT   = 3'd1,
        REG_SHORT_LOW   = 3'd2,
        REG_WR0_LOW     = 3'd3,
        REG_WR1_HIGH    = 3'd4,
        REG_RD_SAMPLE   = 3'd5,
        REG_RD_REST     = 3'd6,
        REG_RECOVERY    = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_RESET       = 4'd1,
        PH_RESET_DONE  = 4'd2,
        PH_DETECT      = 4'd3,
        PH_DETECT_DONE = 4'd4,
        PH_WR_LOW      = 4'd5,
        PH_WR_HIGH1    = 4'd6,
        PH_WR_HIGH0    = 4'd7,
        PH_WR_REC      = 4'd8,
        PH_RD_LOW      = 4'd9,
        PH_RD_HIGH     = 4'd10,
        PH_RD_SAMPLE   = 4'd11,
        PH_RD_REC      = 4'd12
    } t_phase;

    localparam logic [TIME_W-1:0] RST_RESET_LOW = 16'd960;
    localparam logic [TIME_W-1:0] RST_PRES_WAIT = 16'd70;
    localparam logic [TIME_W-1:0] RST_SHORT_LOW = 16'd1;
    localparam logic [TIME_W-1:0] RST_WR0_LOW   = 16'd80;
    localparam logic [TIME_W-1:0] RST_WR1_HIGH  = 16'd49;
    localparam logic [TIME_W-1:0] RST_RD_SAMPLE = 16'd2;
    localparam logic [TIME_W-1:0] RST_RD_REST   = 16'd40;
    localparam logic [TIME_W-1:0] RST_RECOVERY  = 16'd10;
    localparam logic [TIME_W-1:0] START_DELAY   = 16'd1;

    typedef struct packed {
        logic [TIME_W-1:0] reset_low_time;
        logic [TIME_W-1:0] presence_wait_time;
        logic [TIME_W-1:0] short_low_time;
        logic [TIME_W-1:0] write_zero_low_time;
        logic [TIME_W-1:0] write_one_high_time;
        logic [TIME_W-1:0] read_sample_wait;
        logic [TIME_W-1:0] read_rest_time;
        logic [TIME_W-1:0] recovery_time;
    } t_timing;

    typedef struct packed {
        t_opcode     opcode;
        logic [3:0]  byte_index;
        logic [7:0]  byte_value;
        logic [4:0]  write_count;
        logic [4:0]  read_count;
        logic        line_level;
    } t_in_item;

    typedef struct packed {
        logic              drive_level;
        logic              timer_armed;
        logic [TIME_W-1:0] timer_delay;
        logic              done_res;
        logic              no_presence;
        logic              byte_ready;
        logic [3:0]        read_index;
        logic [7:0]        read_value;
    } t_out_item;

endpackage

// ----- rtl/owbm_apb_regs.sv -----
// APB register file holding the eight slot timing values.
// Depends on owbm_pkg for the timing struct, register indexes and reset values.
module owbm_apb_regs import owbm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_timing           o_tim
);

    t_timing  r_tim;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_tim   = r_tim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tim.reset_low_time      <= RST_RESET_LOW;
            r_tim.presence_wait_time  <= RST_PRES_WAIT;
            r_tim.short_low_time      <= RST_SHORT_LOW;
            r_tim.write_zero_low_time <= RST_WR0_LOW;
            r_tim.write_one_high_time <= RST_WR1_HIGH;
            r_tim.read_sample_wait    <= RST_RD_SAMPLE;
            r_tim.read_rest_time      <= RST_RD_REST;
            r_tim.recovery_time       <= RST_RECOVERY;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RESET_LOW: r_tim.reset_low_time      <= pwdata[TIME_W-1:0];
                REG_PRES_WAIT: r_tim.presence_wait_time  <= pwdata[TIME_W-1:0];
                REG_SHORT_LOW: r_tim.short_low_time      <= pwdata[TIME_W-1:0];
                REG_WR0_LOW:   r_tim.write_zero_low_time <= pwdata[TIME_W-1:0];
                REG_WR1_HIGH:  r_tim.write_one_high_time <= pwdata[TIME_W-1:0];
                REG_RD_SAMPLE: r_tim.read_sample_wait    <= pwdata[TIME_W-1:0];
                REG_RD_REST:   r_tim.read_rest_time      <= pwdata[TIME_W-1:0];
                REG_RECOVERY:  r_tim.recovery_time       <= pwdata[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_RESET_LOW: prdata[TIME_W-1:0] = r_tim.reset_low_time;
            REG_PRES_WAIT: prdata[TIME_W-1:0] = r_tim.presence_wait_time;
            REG_SHORT_LOW: prdata[TIME_W-1:0] = r_tim.short_low_time;
            REG_WR0_LOW:   prdata[TIME_W-1:0] = r_tim.write_zero_low_time;
            REG_WR1_HIGH:  prdata[TIME_W-1:0] = r_tim.write_one_high_time;
            REG_RD_SAMPLE: prdata[TIME_W-1:0] = r_tim.read_sample_wait;
            REG_RD_REST:   prdata[TIME_W-1:0] = r_tim.read_rest_time;
            REG_RECOVERY:  prdata[TIME_W-1:0] = r_tim.recovery_time;
            default:       prdata = '0;
        endcase
    end

endmodule

// ----- rtl/owbm_seq.sv -----
// Bus phase sequencer: input register, one-step phase logic, write buffer and result register.
// Depends on owbm_pkg for item structs, phase and opcode enums.
module owbm_seq import owbm_pkg::*; #(
    parameter int MAX_BYTES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  t_timing   i_tim
);

    localparam int CNT_W = $clog2(MAX_BYTES * 8 + 1);
    localparam int NB_W  = $clog2(MAX_BYTES + 1);
    localparam int AD_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int BY_W  = CNT_W - 3;
    localparam logic [NB_W-1:0] MAX_NB = NB_W'(MAX_BYTES);

    // input stage and result stage
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // sequencer state
    t_phase          r_phase, n_phase;
    logic [CNT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic [NB_W-1:0]  r_send, n_send;
    logic [NB_W-1:0]  r_recv, n_recv;
    logic [7:0]       r_shift, n_shift;
    logic             r_drive, n_drive;

    // write buffer
    logic [7:0]      r_mem [MAX_BYTES];
    logic [7:0]      r_rd_byte;
    logic            mem_we;
    logic [AD_W-1:0] mem_waddr;
    logic [AD_W-1:0] rd_addr;
    logic [BY_W-1:0] next_byte;

    logic             proc;
    logic             is_idle;
    logic [CNT_W-1:0] bc_inc;
    logic             wr_more;
    logic             rd_more;
    logic             wr_bit;
    logic [TIME_W-1:0] rest_delay;
    logic [NB_W-1:0]  wc_clamp;
    logic [NB_W-1:0]  rc_clamp;

    assign proc       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign is_idle = (r_phase == PH_IDLE);
    assign bc_inc  = r_bit_cnt + CNT_W'(1);
    assign wr_more = (NB_W + 3)'(bc_inc) < {r_send, 3'b000};
    assign rd_more = (NB_W + 3)'(bc_inc) < {r_recv, 3'b000};
    assign wr_bit  = r_rd_byte[r_bit_cnt[2:0]];
    assign rest_delay = (i_tim.reset_low_time > i_tim.presence_wait_time) ?
                        (i_tim.reset_low_time - i_tim.presence_wait_time) : '0;

    // write_count 0 counts as one byte; both counts saturate at the buffer depth
    always_comb begin
        if (32'(r_in.write_count) > MAX_BYTES) begin
            wc_clamp = MAX_NB;
        end else if (r_in.write_count == 5'd0) begin
            wc_clamp = NB_W'(1);
        end else begin
            wc_clamp = NB_W'(r_in.write_count);
        end
        if (32'(r_in.read_count) > MAX_BYTES) begin
            rc_clamp = MAX_NB;
        end else begin
            rc_clamp = NB_W'(r_in.read_count);
        end
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_send    = r_send;
        n_recv    = r_recv;
        n_shift   = r_shift;
        n_drive   = r_drive;
        mem_we    = 1'b0;
        mem_waddr = AD_W'(r_in.byte_index);
        if (proc) begin
            case (r_in.opcode)
                OP_LOAD: begin
                    mem_we = is_idle && (32'(r_in.byte_index) < MAX_BYTES);
                end
                OP_START: begin
                    if (is_idle) begin
                        n_send    = wc_clamp;
                        n_recv    = rc_clamp;
                        n_bit_cnt = '0;
                        n_phase   = PH_RESET;
                    end
                end
                OP_EXPIRE: begin
                    case (r_phase)
                        PH_IDLE: begin
                        end
                        PH_RESET: begin
                            n_drive = 1'b0;
                            n_phase = PH_RESET_DONE;
                        end
                        PH_RESET_DONE: begin
                            n_drive = 1'b1;
                            n_phase = PH_DETECT;
                        end
                        PH_DETECT: begin
                            n_phase = r_in.line_level ? PH_IDLE : PH_DETECT_DONE;
                        end
                        PH_DETECT_DONE, PH_WR_LOW: begin
                            if (r_phase == PH_DETECT_DONE) begin
                                n_bit_cnt = '0;
                            end
                            n_drive = 1'b0;
                            n_phase = wr_bit ? PH_WR_HIGH1 : PH_WR_HIGH0;
                        end
                        PH_WR_HIGH1: begin
                            n_drive = 1'b1;
                            n_phase = PH_WR_REC;
                        end
                        PH_WR_HIGH0, PH_WR_REC: begin
                            n_drive = 1'b1;
                            if (wr_more) begin
                                n_bit_cnt = bc_inc;
                                n_phase   = PH_WR_LOW;
                            end else if (r_recv == '0) begin
                                n_bit_cnt = bc_inc;
                                n_phase   = PH_IDLE;
                            end else begin
                                n_bit_cnt = '0;
                                n_phase   = PH_RD_LOW;
                            end
                        end
                        PH_RD_LOW: begin
                            n_drive = 1'b0;
                            n_phase = PH_RD_HIGH;
                        end
                        PH_RD_HIGH: begin
                            n_drive = 1'b1;
                            n_phase = PH_RD_SAMPLE;
                        end
                        PH_RD_SAMPLE: begin
                            n_shift[r_bit_cnt[2:0]] = r_in.line_level;
                            n_phase = PH_RD_REC;
                        end
                        PH_RD_REC: begin
                            n_bit_cnt = bc_inc;
                            n_phase   = rd_more ? PH_RD_LOW : PH_IDLE;
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // result item
    always_comb begin
        n_out             = '0;
        n_out.drive_level = n_drive;
        case (r_in.opcode)
            OP_START: begin
                if (is_idle) begin
                    n_out.timer_armed = 1'b1;
                    n_out.timer_delay = START_DELAY;
                end
            end
            OP_EXPIRE: begin
                n_out.timer_armed = 1'b1;
                case (r_phase)
                    PH_RESET:      n_out.timer_delay = i_tim.reset_low_time;
                    PH_RESET_DONE: n_out.timer_delay = i_tim.presence_wait_time;
                    PH_DETECT: begin
                        if (r_in.line_level) begin
                            n_out.timer_armed = 1'b0;
                            n_out.done_res    = 1'b1;
                            n_out.no_presence = 1'b1;
                        end else begin
                            n_out.timer_delay = rest_delay;
                        end
                    end
                    PH_DETECT_DONE, PH_WR_LOW: begin
                        n_out.timer_delay = wr_bit ? i_tim.short_low_time
                                                   : i_tim.write_zero_low_time;
                    end
                    PH_WR_HIGH1:   n_out.timer_delay = i_tim.write_one_high_time;
                    PH_WR_HIGH0, PH_WR_REC: begin
                        if (wr_more || (r_recv != '0)) begin
                            n_out.timer_delay = i_tim.recovery_time;
                        end else begin
                            n_out.timer_armed = 1'b0;
                            n_out.done_res    = 1'b1;
                        end
                    end
                    PH_RD_LOW:     n_out.timer_delay = i_tim.short_low_time;
                    PH_RD_HIGH:    n_out.timer_delay = i_tim.read_sample_wait;
                    PH_RD_SAMPLE: begin
                        n_out.timer_delay = i_tim.read_rest_time;
                        if (r_bit_cnt[2:0] == 3'd7) begin
                            n_out.byte_ready = 1'b1;
                            n_out.read_index = 4'(r_bit_cnt >> 3);
                            n_out.read_value = n_shift;
                        end
                    end
                    PH_RD_REC: begin
                        if (rd_more) begin
                            n_out.timer_delay = i_tim.recovery_time;
                        end else begin
                            n_out.timer_armed = 1'b0;
                            n_out.done_res    = 1'b1;
                        end
                    end
                    default:       n_out.timer_armed = 1'b0;
                endcase
            end
            default: begin
            end
        endcase
    end

    // prefetch the byte the counter will point at, so a write slot finds it ready
    assign next_byte = n_bit_cnt[CNT_W-1:3];
    assign rd_addr   = (32'(next_byte) < MAX_BYTES) ? AD_W'(next_byte) : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_in.byte_value;
        end
        r_rd_byte <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_bit_cnt   <= '0;
            r_send      <= NB_W'(1);
            r_recv      <= '0;
            r_shift     <= '0;
            r_drive     <= 1'b1;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_send    <= n_send;
            r_recv    <= n_recv;
            r_shift   <= n_shift;
            r_drive   <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (proc) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/one_wire_bus_master_unit.sv -----
// One-wire bus master unit: top level joining the APB timing registers and the sequencer.
// Depends on owbm_pkg, owbm_apb_regs and owbm_seq.
//
// Drives a one-wire bus against an external microsecond timer. Load items fill the
// write buffer, a start item opens a transaction (reset, presence check, LSB-first write
// bytes, then read bytes), and each timer-expiry item, carrying the sampled line, moves
// the bus on by one phase. Every item gives exactly one result: the bus drive, the next
// delay to arm, completion with the no-presence flag, and each received byte. Load and
// start items are ignored while a transaction runs. The unit takes one item per clock
// while its result is not stalled. An accepted item is held in the input register and
// is stepped through the phase logic into the result register; a stalled result holds
// the input side back. The write buffer read is prefetched when the bit counter moves,
// so the byte is ready for the write slot. The slot timings are APB registers at byte
// addresses 0 to 28, and the user must see that they are written only while idle; the
// block itself does not enforce this.
module one_wire_bus_master_unit import owbm_pkg::*; #(
    parameter int MAX_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_timing tim;

    owbm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_tim   (tim)
    );

    owbm_seq #(
        .MAX_BYTES (MAX_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_tim       (tim)
    );

endmodule

// ----- rtl/owbm_checker.sv -----
// Port-level checks for the one-wire bus master unit, attached by bind.
// Depends on owbm_pkg for the result item struct.
module owbm_checker import owbm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_out_item         o_out_data,
    input logic              pready
);

    // nothing is left in flight across a reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_delay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.timer_armed |-> o_out_data.timer_delay == '0)
        else $error("delay given with no timer request");

    // a finished transaction always leaves the bus released and stops the timer
    a_done_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.done_res || o_out_data.no_presence) |->
            o_out_data.done_res && o_out_data.drive_level && !o_out_data.timer_armed
            && !o_out_data.byte_ready)
        else $error("bad completion result");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .pready      (pready)
);
